// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, checked during reset as well.
`define SPK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is masked while reset is applied.
`define SPK_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== design/spk_pkg.sv =====
// Shared constants for the Speck encryption pipeline.
package spk_pkg;

  localparam int FIELD_BITS     = 64;
  localparam int TDATA_BITS     = 2 * FIELD_BITS;
  localparam int KEY_REG_COUNT  = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int KEY_SEL_BITS   = $clog2(KEY_REG_COUNT);

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_WORD_3 = 3'd3;

  // default configuration (Speck128/128)
  localparam int DEF_WORD_BITS      = 64;
  localparam int DEF_KEY_WORD_COUNT = 2;
  localparam int DEF_ROUND_COUNT    = 32;
  localparam int DEF_RIGHT_ROTATE   = 8;
  localparam int DEF_LEFT_ROTATE    = 3;

endpackage

// ===== design/spk_cell.sv =====
// One Speck round cell: a data round and a key schedule step, both registered.
module spk_cell #(
  parameter int WORD_BITS      = spk_pkg::DEF_WORD_BITS,
  parameter int KEY_WORD_COUNT = spk_pkg::DEF_KEY_WORD_COUNT,
  parameter int RIGHT_ROTATE   = spk_pkg::DEF_RIGHT_ROTATE,
  parameter int LEFT_ROTATE    = spk_pkg::DEF_LEFT_ROTATE,
  parameter int ROUND_IDX      = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [WORD_BITS-1:0] in_x,
  input  logic [WORD_BITS-1:0] in_y,
  input  logic [WORD_BITS-1:0] in_k,
  input  logic [WORD_BITS-1:0] in_l [KEY_WORD_COUNT-1],
  output logic                 out_valid,
  output logic [WORD_BITS-1:0] out_x,
  output logic [WORD_BITS-1:0] out_y,
  output logic [WORD_BITS-1:0] out_k,
  output logic [WORD_BITS-1:0] out_l [KEY_WORD_COUNT-1]
);

  localparam int LQ = KEY_WORD_COUNT - 1;
  localparam logic [WORD_BITS-1:0] ROUND_CONST = WORD_BITS'(ROUND_IDX);

  logic                 valid_r;
  logic [WORD_BITS-1:0] x_r, y_r, k_r;
  logic [WORD_BITS-1:0] l_r [LQ];

  logic [WORD_BITS-1:0] x_nxt, y_nxt, k_nxt, lx_nxt;
  logic [WORD_BITS-1:0] l_nxt [LQ];

  // data round keyed by this cell's round key
  always_comb begin
    x_nxt = (((in_x >> RIGHT_ROTATE) | (in_x << (WORD_BITS - RIGHT_ROTATE))) + in_y) ^ in_k;
    y_nxt = ((in_y << LEFT_ROTATE) | (in_y >> (WORD_BITS - LEFT_ROTATE))) ^ x_nxt;
  end

  // key schedule step, the round index acts as key
  always_comb begin
    lx_nxt = (((in_l[0] >> RIGHT_ROTATE) | (in_l[0] << (WORD_BITS - RIGHT_ROTATE)))
              + in_k) ^ ROUND_CONST;
    k_nxt  = ((in_k << LEFT_ROTATE) | (in_k >> (WORD_BITS - LEFT_ROTATE))) ^ lx_nxt;
  end

  // the l words form a queue: used word leaves the front, new one joins the back
  genvar j;
  generate
    for (j = 0; j < LQ - 1; j++) begin : g_shift
      assign l_nxt[j] = in_l[j+1];
    end
  endgenerate
  assign l_nxt[LQ-1] = lx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      k_r <= k_nxt;
      l_r <= l_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_k     = k_r;
  assign out_l     = l_r;

endmodule

// ===== design/speck_block_encrypt_top.sv =====
// Speck block encryption: a chain of round cells with the key schedule riding along.
//
// Usage:
//   Key words are written on the cfg port (cfg_we, cfg_index, cfg_data) while
//   the block is idle; indexes above the last key register are ignored. Only
//   the first KEY_WORD_COUNT key words take part in the schedule.
//   Plaintext items enter on the in_ stream, ciphertext items leave on the
//   out_ stream, one result per item, in order.
//   The chain holds one round cell per round, each holding one item.
//   Throughput is one item per cycle while the receiver does not stall;
//   each item carries its own key schedule state through the cells, so no
//   round key store and no expansion pass exist.
//   When the receiver stalls with a result waiting, the whole chain holds and
//   in_tready drops in the same cycle; otherwise in_tready is high, also while
//   the last cell is being drained.
//   Reset (synchronous, active low) clears all key words to zero and empties
//   the chain; the block is ready in the first cycle after reset.
//   With WORD_BITS below 64, only the low bits of each field are used and the
//   upper result bits read zero.
module speck_block_encrypt_top #(
  parameter int WORD_BITS      = spk_pkg::DEF_WORD_BITS,
  parameter int KEY_WORD_COUNT = spk_pkg::DEF_KEY_WORD_COUNT,
  parameter int ROUND_COUNT    = spk_pkg::DEF_ROUND_COUNT,
  parameter int RIGHT_ROTATE   = spk_pkg::DEF_RIGHT_ROTATE,
  parameter int LEFT_ROTATE    = spk_pkg::DEF_LEFT_ROTATE
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [spk_pkg::TDATA_BITS-1:0]        in_tdata,   // plain_x, plain_y
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [spk_pkg::TDATA_BITS-1:0]        out_tdata,  // cipher_x, cipher_y
  input  logic                                  cfg_we,
  input  logic [spk_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [spk_pkg::FIELD_BITS-1:0]        cfg_data
);

  localparam int FB = spk_pkg::FIELD_BITS;
  localparam int LQ = KEY_WORD_COUNT - 1;

  logic [FB-1:0] key_r [spk_pkg::KEY_REG_COUNT];

  logic                 v_c [ROUND_COUNT+1];
  logic [WORD_BITS-1:0] x_c [ROUND_COUNT+1];
  logic [WORD_BITS-1:0] y_c [ROUND_COUNT+1];
  logic [WORD_BITS-1:0] k_c [ROUND_COUNT+1];
  logic [WORD_BITS-1:0] l_c [ROUND_COUNT+1][LQ];

  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spk_pkg::KEY_REG_COUNT; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index <= spk_pkg::REG_KEY_WORD_3)) begin
      key_r[cfg_index[spk_pkg::KEY_SEL_BITS-1:0]] <= cfg_data;
    end
  end

  // chain advances unless a finished item is held at the output
  assign en        = !v_c[ROUND_COUNT] || out_tready;
  assign in_tready = en;

  assign v_c[0] = in_tvalid;
  assign x_c[0] = in_tdata[WORD_BITS-1:0];
  assign y_c[0] = in_tdata[FB+WORD_BITS-1:FB];
  // last key word is round key 0, the others fill the queue from the top down
  assign k_c[0] = key_r[LQ][WORD_BITS-1:0];

  genvar g;
  generate
    for (g = 0; g < LQ; g++) begin : g_lq
      assign l_c[0][g] = key_r[LQ-1-g][WORD_BITS-1:0];
    end

    for (g = 0; g < ROUND_COUNT; g++) begin : g_round
      spk_cell #(
        .WORD_BITS      (WORD_BITS),
        .KEY_WORD_COUNT (KEY_WORD_COUNT),
        .RIGHT_ROTATE   (RIGHT_ROTATE),
        .LEFT_ROTATE    (LEFT_ROTATE),
        .ROUND_IDX      (g)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_c[g]),
        .in_x      (x_c[g]),
        .in_y      (y_c[g]),
        .in_k      (k_c[g]),
        .in_l      (l_c[g]),
        .out_valid (v_c[g+1]),
        .out_x     (x_c[g+1]),
        .out_y     (y_c[g+1]),
        .out_k     (k_c[g+1]),
        .out_l     (l_c[g+1])
      );
    end
  endgenerate

  assign out_tvalid = v_c[ROUND_COUNT];
  assign out_tdata  = {FB'(y_c[ROUND_COUNT]), FB'(x_c[ROUND_COUNT])};

endmodule

// ===== design/spk_checker.sv =====
// Port-level checker for the Speck encryption top, bound to it.
`include "assert_macros.svh"

module spk_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [spk_pkg::TDATA_BITS-1:0]     out_tdata
);

  logic out_stall;

  assign out_stall = out_tvalid && !out_tready;

  // a stalled result stays put
  `SPK_ASSERT_RUN(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "held item changed")

  // reset empties the chain
  `SPK_ASSERT(a_rst_empty, !rst_n |=> !out_tvalid, "out_tvalid set right after reset")

  // input side only backs up behind a held result
  `SPK_ASSERT_RUN(a_ready_free, !out_stall |-> in_tready, "in_tready low without output stall")

  // no acceptance while the output is held
  `SPK_ASSERT_RUN(a_no_accept_stall, out_stall |-> !(in_tvalid && in_tready), "accepted while stalled")

endmodule

bind speck_block_encrypt_top spk_checker u_spk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/tb_speck_block_encrypt_top.sv =====
// Testbench for speck_block_encrypt_top: random and directed blocks against a Speck predictor.
module tb_speck_block_encrypt_top;
  import spk_pkg::*;

  localparam int WORD_BITS      = DEF_WORD_BITS;
  localparam int KEY_WORD_COUNT = DEF_KEY_WORD_COUNT;
  localparam int ROUND_COUNT    = DEF_ROUND_COUNT;
  localparam int RIGHT_ROTATE   = DEF_RIGHT_ROTATE;
  localparam int LEFT_ROTATE    = DEF_LEFT_ROTATE;
  localparam int CLK_PERIOD     = 20;
  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int PRINT_CAP      = 30;

  localparam logic [FIELD_BITS-1:0] WORD_MASK =
    (WORD_BITS >= FIELD_BITS) ? '1 : ((FIELD_BITS'(1) << WORD_BITS) - 1);

  typedef struct packed {
    logic [FIELD_BITS-1:0] cipher_y;
    logic [FIELD_BITS-1:0] cipher_x;
  } cipher_block_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [TDATA_BITS-1:0]     in_tdata;   // plain_x, plain_y
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [TDATA_BITS-1:0]     out_tdata;  // cipher_x, cipher_y
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [FIELD_BITS-1:0]     cfg_data;

  // predictor state
  logic [FIELD_BITS-1:0] key_shadow [0:KEY_REG_COUNT-1];
  logic [FIELD_BITS-1:0] round_keys [0:ROUND_COUNT-1];
  cipher_block_t         pending_ciphers [$];

  int  errors          = 0;
  int  blocks_sent     = 0;
  int  results_checked = 0;
  int  key_writes      = 0;
  int  held_cycles     = 0;
  int  hold_off_cycles = 0;
  bit  tight_send      = 1'b0;
  bit  tight_recv      = 1'b0;

  speck_block_encrypt_top #(
    .WORD_BITS     (WORD_BITS),
    .KEY_WORD_COUNT(KEY_WORD_COUNT),
    .ROUND_COUNT   (ROUND_COUNT),
    .RIGHT_ROTATE  (RIGHT_ROTATE),
    .LEFT_ROTATE   (LEFT_ROTATE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d results outstanding", pending_ciphers.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic logic [FIELD_BITS-1:0] rot_right(input logic [FIELD_BITS-1:0] v,
                                                      input int s);
    logic [FIELD_BITS-1:0] w;
    w = v & WORD_MASK;
    return ((w >> s) | (w << (WORD_BITS - s))) & WORD_MASK;
  endfunction

  function automatic logic [FIELD_BITS-1:0] rot_left(input logic [FIELD_BITS-1:0] v,
                                                     input int s);
    logic [FIELD_BITS-1:0] w;
    w = v & WORD_MASK;
    return ((w << s) | (w >> (WORD_BITS - s))) & WORD_MASK;
  endfunction

  // one round: returns {y_next, x_next}
  function automatic logic [2*FIELD_BITS-1:0] mix_round(input logic [FIELD_BITS-1:0] rk,
                                                        input logic [FIELD_BITS-1:0] x,
                                                        input logic [FIELD_BITS-1:0] y);
    logic [FIELD_BITS-1:0] a;
    a = ((rot_right(x, RIGHT_ROTATE) + y) & WORD_MASK) ^ (rk & WORD_MASK);
    return {rot_left(y, LEFT_ROTATE) ^ a, a};
  endfunction

  // key schedule reuses the round with the round index as key
  function automatic void rebuild_round_keys();
    logic [FIELD_BITS-1:0]   lwords [0:2];
    logic [2*FIELD_BITS-1:0] r;
    int                      slot;
    slot = 0;
    round_keys[0] = key_shadow[KEY_WORD_COUNT-1] & WORD_MASK;
    for (int i = 1; i < KEY_WORD_COUNT; i++)
      lwords[i-1] = key_shadow[KEY_WORD_COUNT-1-i] & WORD_MASK;
    for (int i = 0; i + 1 < ROUND_COUNT; i++) begin
      r = mix_round(FIELD_BITS'(i), lwords[slot], round_keys[i]);
      lwords[slot] = r[FIELD_BITS-1:0];
      round_keys[i+1] = r[2*FIELD_BITS-1:FIELD_BITS];
      slot = (slot + 1 >= KEY_WORD_COUNT - 1) ? 0 : slot + 1;
    end
  endfunction

  function automatic cipher_block_t encipher_block(input logic [FIELD_BITS-1:0] px,
                                                   input logic [FIELD_BITS-1:0] py);
    logic [FIELD_BITS-1:0]   x, y;
    logic [2*FIELD_BITS-1:0] r;
    cipher_block_t           c;
    x = px & WORD_MASK;
    y = py & WORD_MASK;
    for (int i = 0; i < ROUND_COUNT; i++) begin
      r = mix_round(round_keys[i], x, y);
      x = r[FIELD_BITS-1:0];
      y = r[2*FIELD_BITS-1:FIELD_BITS];
    end
    c.cipher_x = x;
    c.cipher_y = y;
    return c;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [FIELD_BITS-1:0] rand_word();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return '1;
    if (r < 20) return FIELD_BITS'(1) << $urandom_range(FIELD_BITS - 1);
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    if (tight_send) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // returns right after the accepting edge; in_tvalid is left high for a back-to-back item
  task automatic send_block(input logic [FIELD_BITS-1:0] px, input logic [FIELD_BITS-1:0] py);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_ciphers.push_back(encipher_block(px, py));
    blocks_sent++;
  endtask

  // stop offering, wait for every result; with settle, let the chain run empty too
  task automatic drain_results(input bit settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_ciphers.size() != 0) @(posedge clk);
    if (settle) repeat (ROUND_COUNT + 4) @(posedge clk);
  endtask

  task automatic write_key_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [FIELD_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    key_writes++;
    if (idx <= REG_KEY_WORD_3) begin
      key_shadow[idx[KEY_SEL_BITS-1:0]] = value;
      rebuild_round_keys();
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_reset_schedule();
    send_block('0, '0);
    send_block('1, '1);
    send_block('1, '0);
    send_block('0, '1);
    send_block({FIELD_BITS/2{2'b10}}, {FIELD_BITS/2{2'b01}});
    send_block(FIELD_BITS'(1), FIELD_BITS'(1) << (FIELD_BITS - 1));
    send_block(FIELD_BITS'(1) << (FIELD_BITS - 1), FIELD_BITS'(1));
    send_block(64'h6c61766975716520, 64'h7469206564616d20);
  endtask

  task automatic test_key_extremes();
    drain_results(1);
    for (int i = 0; i < KEY_REG_COUNT; i++)
      write_key_reg(REG_KEY_WORD_0 + CFG_INDEX_BITS'(i), '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h6c61766975716520, 64'h7469206564616d20);
    send_block(rand_word(), rand_word());
    // standard 128/128 key layout
    drain_results(1);
    write_key_reg(REG_KEY_WORD_0, 64'h0f0e0d0c0b0a0908);
    write_key_reg(REG_KEY_WORD_0 + CFG_INDEX_BITS'(1), 64'h0706050403020100);
    send_block(64'h6c61766975716520, 64'h7469206564616d20);
    send_block('1, '0);
    // index past the last key register must be dropped
    drain_results(1);
    write_key_reg(REG_KEY_WORD_3 + CFG_INDEX_BITS'($urandom_range(4, 1)), {$urandom, $urandom});
    send_block('0, '1);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    // words past the key length are stored but unused
    drain_results(1);
    write_key_reg(REG_KEY_WORD_3 - CFG_INDEX_BITS'(1), {FIELD_BITS/2{2'b10}});
    write_key_reg(REG_KEY_WORD_3, {FIELD_BITS/2{2'b01}});
    send_block('0, '0);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic test_random_keys();
    for (int phase = 0; phase < 10; phase++) begin
      drain_results(1);
      for (int i = 0; i < KEY_REG_COUNT; i++)
        write_key_reg(REG_KEY_WORD_0 + CFG_INDEX_BITS'(i), rand_word());
      if ($urandom_range(2) == 0)
        write_key_reg(REG_KEY_WORD_3 + CFG_INDEX_BITS'($urandom_range(4, 1)), rand_word());
      tight_send = (phase == 3 || phase == 8);
      tight_recv = (phase == 3 || phase == 6);
      for (int n = 0; n < 120; n++) begin
        send_block(rand_word(), rand_word());
        if ($urandom_range(99) == 0) drain_results(0);
      end
    end
    tight_send = 1'b0;
    tight_recv = 1'b0;
  endtask

  task automatic test_backpressure();
    drain_results(1);
    write_key_reg(REG_KEY_WORD_0, rand_word());
    write_key_reg(REG_KEY_WORD_0 + CFG_INDEX_BITS'(1), rand_word());
    // sink holds off long enough for the chain to fill and push back
    hold_off_cycles = 4 * ROUND_COUNT + $urandom_range(150, 100);
    tight_send = 1'b1;
    for (int n = 0; n < 60; n++) send_block(rand_word(), rand_word());
    tight_send = 1'b0;
    for (int n = 0; n < 20; n++) send_block(rand_word(), rand_word());
  endtask

  // ---------------- result side ----------------

  initial begin : result_sink
    int run;
    int r;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        hold_off_cycles--;
        run = 0;
      end else if (tight_recv) begin
        out_tready <= 1'b1;
      end else if (run > 0) begin
        run--;
      end else begin
        r = $urandom_range(99);
        if (r < 65) begin
          out_tready <= 1'b1;
          run = $urandom_range(20);
        end else if (r < 95) begin
          out_tready <= 1'b0;
          run = $urandom_range(2);
        end else begin
          out_tready <= 1'b0;
          run = $urandom_range(40, 10);
        end
      end
    end
  end

  always @(posedge clk) begin : cipher_check
    cipher_block_t want;
    if (rst_n) begin
      if (in_tvalid && !in_tready) held_cycles++;
      if (out_tvalid && out_tready) begin
        if (pending_ciphers.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", out_tdata));
        end else begin
          want = pending_ciphers.pop_front();
          results_checked++;
          if (out_tdata[FIELD_BITS-1:0] !== want.cipher_x)
            report_mismatch($sformatf("cipher_x got %h want %h",
                                      out_tdata[FIELD_BITS-1:0], want.cipher_x));
          if (out_tdata[TDATA_BITS-1:FIELD_BITS] !== want.cipher_y)
            report_mismatch($sformatf("cipher_y got %h want %h",
                                      out_tdata[TDATA_BITS-1:FIELD_BITS], want.cipher_y));
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < KEY_REG_COUNT; i++) key_shadow[i] = '0;
    rebuild_round_keys();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_schedule();
    test_key_extremes();
    test_random_keys();
    test_backpressure();
    drain_results(1);

    $display("Encrypted %0d blocks over %0d key register writes; %0d results checked.",
             blocks_sent, key_writes, results_checked);
    $display("Input was held back for %0d cycles; %0d mismatches seen.", held_cycles, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
